/* src/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and elaboration helpers for the pre-trade risk gate.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  // Bus geometry of the register port
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  // Default tuning values
  localparam int unsigned PRICE_STEP_DEF     = 1;
  localparam int unsigned MAX_PER_UPDATE_DEF = 8;

  // Register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_MAX_ORDER_QTY  = 3'd0;
  localparam logic [2:0] REG_MIN_PRICE      = 3'd1;
  localparam logic [2:0] REG_MAX_PRICE      = 3'd2;
  localparam logic [2:0] REG_MAX_SIDE_QTY   = 3'd3;
  localparam logic [2:0] REG_MAX_SIDE_EXPO  = 3'd4;
  localparam logic [2:0] REG_MAX_PROJ_POS   = 3'd5;
  localparam logic [2:0] REG_MAX_PER_SECOND = 3'd6;
  localparam logic [2:0] REG_MAX_IN_FLIGHT  = 3'd7;

  // Event codes
  typedef enum logic [2:0] {
    OP_NEW      = 3'd0,
    OP_MODIFY   = 3'd1,
    OP_MD_UPD   = 3'd2,
    OP_SENT     = 3'd3,
    OP_ACKED    = 3'd4,
    OP_TICK     = 3'd5,
    OP_SHUTDOWN = 3'd6
  } op_e;

  // Reject reasons
  typedef enum logic [3:0] {
    RSN_NONE       = 4'd0,
    RSN_ORDER_QTY  = 4'd1,
    RSN_SIDE_QTY   = 4'd2,
    RSN_EXPOSURE   = 4'd3,
    RSN_PRICE      = 4'd4,
    RSN_POSITION   = 4'd5,
    RSN_PER_SECOND = 4'd6,
    RSN_PER_MD     = 4'd7,
    RSN_IN_FLIGHT  = 4'd8,
    RSN_SHUTDOWN   = 4'd9
  } reason_e;

  typedef struct packed {
    logic [2:0]         op;
    logic               side;
    logic [31:0]        quantity;
    logic [31:0]        price;
    logic signed [31:0] position;
    logic [31:0]        outstanding_buy;
    logic [31:0]        outstanding_sell;
    logic               old_side;
    logic [31:0]        old_qty;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] reason;
    logic       halted;
  } rsp_t;

  typedef struct packed {
    logic [31:0] max_order_qty;
    logic [31:0] min_price;
    logic [31:0] max_price;
    logic [31:0] max_side_qty;
    logic [32:0] max_side_exposure;
    logic [32:0] max_projected_position;
    logic [15:0] max_per_second;
    logic [15:0] max_in_flight;
  } cfg_t;

  typedef struct packed {
    logic [15:0] sent_this_second;
    logic [15:0] sent_this_update;
    logic [15:0] in_flight;
    logic        halt_flag;
  } cnt_t;

  // Number of trailing zero bits of a price step
  function automatic int unsigned prc_ctz(int unsigned v);
    int unsigned n;
    logic        found;
    n     = 0;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!found && v[i]) begin
        n     = i;
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Inverse of an odd value modulo 2^32 (Newton iteration)
  function automatic logic [31:0] prc_inv32(logic [31:0] o);
    logic [31:0] x;
    x = o;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - o * x);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

/* src/prc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// prc_cfg_regs
// Limit registers behind the register port, with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_cfg_regs
  import prc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:3];

  // Write on the access cycle of a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_order_qty: '0, min_price: '0, max_price: '1, max_side_qty: '0,
                 max_side_exposure: '0, max_projected_position: '0,
                 max_per_second: '0, max_in_flight: '0};
    end else if (wr_en) begin
      case (idx)
        REG_MAX_ORDER_QTY:  cfg_q.max_order_qty          <= pwdata[31:0];
        REG_MIN_PRICE:      cfg_q.min_price              <= pwdata[31:0];
        REG_MAX_PRICE:      cfg_q.max_price              <= pwdata[31:0];
        REG_MAX_SIDE_QTY:   cfg_q.max_side_qty           <= pwdata[31:0];
        REG_MAX_SIDE_EXPO:  cfg_q.max_side_exposure      <= pwdata[32:0];
        REG_MAX_PROJ_POS:   cfg_q.max_projected_position <= pwdata[32:0];
        REG_MAX_PER_SECOND: cfg_q.max_per_second         <= pwdata[15:0];
        REG_MAX_IN_FLIGHT:  cfg_q.max_in_flight          <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    case (idx)
      REG_MAX_ORDER_QTY:  prdata = {32'd0, cfg_q.max_order_qty};
      REG_MIN_PRICE:      prdata = {32'd0, cfg_q.min_price};
      REG_MAX_PRICE:      prdata = {32'd0, cfg_q.max_price};
      REG_MAX_SIDE_QTY:   prdata = {32'd0, cfg_q.max_side_qty};
      REG_MAX_SIDE_EXPO:  prdata = {31'd0, cfg_q.max_side_exposure};
      REG_MAX_PROJ_POS:   prdata = {31'd0, cfg_q.max_projected_position};
      REG_MAX_PER_SECOND: prdata = {48'd0, cfg_q.max_per_second};
      REG_MAX_IN_FLIGHT:  prdata = {48'd0, cfg_q.max_in_flight};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/prc_check.sv */
// ----------------------------------------------------------------------------
// prc_check
// Single-pass evaluation of one event: limit checks, reply and next counters.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_check
  import prc_pkg::*;
#(
  parameter int unsigned PRICE_STEP     = PRICE_STEP_DEF,
  parameter int unsigned MAX_PER_UPDATE = MAX_PER_UPDATE_DEF
) (
  input  wire req_t req_i,
  input  wire cfg_t cfg_i,
  input  wire cnt_t cnt_i,
  output rsp_t      rsp_o,
  output cnt_t      cnt_o
);

  // Tick alignment: divisible by 2^TZ and by the odd part ODD.
  // x is a multiple of ODD iff x * inv(ODD) mod 2^32 <= (2^32-1) / ODD.
  localparam int unsigned TZ       = prc_ctz(PRICE_STEP);
  localparam logic [31:0] ODD      = 32'(PRICE_STEP >> TZ);
  localparam logic [31:0] ODD_INV  = prc_inv32(ODD);
  localparam logic [31:0] BOUND    = 32'hFFFF_FFFF / ODD;
  localparam logic [31:0] LOW_MASK = 32'((64'd1 << TZ) - 64'd1);
  localparam logic [15:0] PER_UPD  = 16'(MAX_PER_UPDATE);

  logic               is_mod;
  logic [31:0]        obuy;
  logic [31:0]        osell;
  logic [32:0]        side_out;
  logic signed [34:0] pos_x;
  logic signed [34:0] expo;
  logic [31:0]        odd_prod;
  logic               aligned;
  logic               price_bad;
  reason_e            rsn;

  assign is_mod = (req_i.op == OP_MODIFY);

  // Remove the old quantity from its side, clamped at zero
  always_comb begin
    obuy  = req_i.outstanding_buy;
    osell = req_i.outstanding_sell;
    if (is_mod && !req_i.old_side) begin
      obuy = (req_i.old_qty < obuy) ? obuy - req_i.old_qty : 32'd0;
    end
    if (is_mod && req_i.old_side) begin
      osell = (req_i.old_qty < osell) ? osell - req_i.old_qty : 32'd0;
    end
  end

  // Side quantity after this order and the exposure on that side
  assign side_out = {1'b0, (req_i.side ? osell : obuy)} + {1'b0, req_i.quantity};
  assign pos_x    = 35'(req_i.position);
  assign expo     = (req_i.side ? -pos_x : pos_x) + $signed({2'b00, side_out});

  // Price range and tick alignment
  assign odd_prod  = (req_i.price >> TZ) * ODD_INV;
  assign aligned   = ((req_i.price & LOW_MASK) == 32'd0) && (odd_prod <= BOUND);
  assign price_bad = (req_i.price < cfg_i.min_price) || (req_i.price > cfg_i.max_price) ||
                     !aligned;

  // Pick the first failing check
  always_comb begin
    if (cnt_i.halt_flag) begin
      rsn = RSN_SHUTDOWN;
    end else if (req_i.quantity > cfg_i.max_order_qty) begin
      rsn = RSN_ORDER_QTY;
    end else if (price_bad) begin
      rsn = RSN_PRICE;
    end else if (side_out > {1'b0, cfg_i.max_side_qty}) begin
      rsn = RSN_SIDE_QTY;
    end else if (expo > $signed({2'b00, cfg_i.max_side_exposure})) begin
      rsn = RSN_EXPOSURE;
    end else if (expo > $signed({2'b00, cfg_i.max_projected_position})) begin
      rsn = RSN_POSITION;
    end else if (cnt_i.sent_this_second >= cfg_i.max_per_second) begin
      rsn = RSN_PER_SECOND;
    end else if (cnt_i.sent_this_update >= PER_UPD) begin
      rsn = RSN_PER_MD;
    end else if (cnt_i.in_flight >= cfg_i.max_in_flight) begin
      rsn = RSN_IN_FLIGHT;
    end else begin
      rsn = RSN_NONE;
    end
  end

  // Reply and counter update per event
  always_comb begin
    cnt_o          = cnt_i;
    rsp_o.accepted = 1'b1;
    rsp_o.reason   = RSN_NONE;
    case (req_i.op)
      OP_NEW, OP_MODIFY: begin
        rsp_o.reason   = rsn;
        rsp_o.accepted = (rsn == RSN_NONE);
      end
      OP_MD_UPD: begin
        cnt_o.sent_this_update = '0;
      end
      OP_SENT: begin
        if (cnt_i.sent_this_second != '1) begin
          cnt_o.sent_this_second = cnt_i.sent_this_second + 16'd1;
        end
        if (cnt_i.sent_this_update != '1) begin
          cnt_o.sent_this_update = cnt_i.sent_this_update + 16'd1;
        end
        if (cnt_i.in_flight != '1) begin
          cnt_o.in_flight = cnt_i.in_flight + 16'd1;
        end
      end
      OP_ACKED: begin
        if (cnt_i.in_flight != '0) begin
          cnt_o.in_flight = cnt_i.in_flight - 16'd1;
        end
      end
      OP_TICK: begin
        cnt_o.sent_this_second = '0;
      end
      OP_SHUTDOWN: begin
        cnt_o.halt_flag = 1'b1;
      end
      default: begin
        rsp_o.accepted = 1'b0;
      end
    endcase
    rsp_o.halted = cnt_o.halt_flag;
  end

endmodule

`default_nettype wire

/* src/pretrade_risk_check_core.sv */
// ----------------------------------------------------------------------------
// pretrade_risk_check_core
// Pre-trade risk gate: checks orders and tracks rate and in-flight counters.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (in_valid_i / in_ready_o / in_data_i),
//   one event per transfer. Replies leave on the out channel (out_valid_o /
//   out_ready_i / out_data_o), exactly one reply per request, in order.
//   Limits are set through the register port (8-byte stride) while idle.
//   The user must keep to this; the block does not enforce it. Requests
//   are evaluated from the input register and move into the result
//   register when it has room. Throughput: one request per cycle while
//   replies are taken; the input and result registers each hold one item,
//   and the counters are updated by the single evaluation stage between them.
//   Receiver stall: the reply holds in the result register; the input
//   register still takes one more request, then in_ready_o drops until
//   the reply is taken.
//   Reset: both registers empty, counters and the shutdown flag clear,
//   limits at their reset values (max_price all ones, the rest zero).
// ----------------------------------------------------------------------------
`default_nettype none

module pretrade_risk_check_core
  import prc_pkg::*;
#(
  parameter int unsigned PRICE_STEP     = PRICE_STEP_DEF,
  parameter int unsigned MAX_PER_UPDATE = MAX_PER_UPDATE_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire req_t               in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rsp_t                    out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t cfg;
  cnt_t cnt_q;
  cnt_t cnt_d;
  req_t req_q;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic req_vld_q;
  logic rsp_vld_q;
  logic advance;

  prc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prc_check #(
    .PRICE_STEP     (PRICE_STEP),
    .MAX_PER_UPDATE (MAX_PER_UPDATE)
  ) u_check (
    .req_i (req_q),
    .cfg_i (cfg),
    .cnt_i (cnt_q),
    .rsp_o (rsp_d),
    .cnt_o (cnt_d)
  );

  // Move the held request into the result register when it has room
  assign advance    = req_vld_q && (!rsp_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      req_vld_q <= 1'b1;
    end else if (advance) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  // Counters and shutdown flag advance with each evaluated request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (advance) begin
      cnt_q <= cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign out_data_o  = rsp_q;

endmodule

`default_nettype wire

/* src/prc_checker.sv */
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks on the risk gate, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_checker
  import prc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire rsp_t out_data_o
);

  logic [1:0] pend_q;
  logic       halt_seen_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Track requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // Remember a delivered shutdown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
    end else if (out_xfer && out_data_o.halted) begin
      halt_seen_q <= 1'b1;
    end
  end

  a_reply_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("reply without a pending request");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && halt_seen_q) |-> out_data_o.halted)
    else $error("shutdown flag dropped after it was reported");

  a_accept_no_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted) |-> out_data_o.reason == RSN_NONE)
    else $error("accepted reply carries a reject reason");

  a_shutdown_reason_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reason == RSN_SHUTDOWN) |-> out_data_o.halted)
    else $error("shutdown reject without the shutdown flag");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled reply changed or dropped");

endmodule

bind pretrade_risk_check_core prc_checker u_prc_checker (.*);

`default_nettype wire

/* tb/tb_pretrade_risk_check_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pretrade_risk_check_core
// Self-checking bench for the pre-trade risk gate. A behavioral predictor
// tracks the limits and the rate counters and works out the verdict of
// every request. Directed tests walk every reject reason, the modify clamp,
// field extremes and counter build-up; random phases run under several
// limit settings with bursty input, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------

module tb_pretrade_risk_check_core;
  import prc_pkg::*;

  localparam logic [2:0]  OP_UNUSED     = 3'd7;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned SAT_SENTS     = 40;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rsp_t              out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [PDATA_W-1:0] pwdata     = '0;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  // Predictor copy of the limits and counters
  cfg_t lim;
  cnt_t cnt;
  rsp_t pending_verdicts[$];
  int   mismatches   = 0;
  int   burst_left   = 0;
  bit   hold_off_req = 1'b0;

  pretrade_risk_check_core #(
    .PRICE_STEP     (PRICE_STEP_DEF),
    .MAX_PER_UPDATE (MAX_PER_UPDATE_DEF)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Verdict of one request; advances the predicted counters
  function automatic rsp_t risk_verdict(input req_t r);
    rsp_t        o;
    reason_e     why;
    logic [31:0] obuy;
    logic [31:0] osell;
    logic [32:0] side_out;
    longint      expo;
    o.accepted = 1'b1;
    why        = RSN_NONE;
    case (r.op)
      OP_NEW, OP_MODIFY: begin
        obuy  = r.outstanding_buy;
        osell = r.outstanding_sell;
        if (r.op == OP_MODIFY) begin
          // Remove the old quantity from its side, clamp at zero
          if (!r.old_side) obuy = obuy - ((r.old_qty < obuy) ? r.old_qty : obuy);
          else osell = osell - ((r.old_qty < osell) ? r.old_qty : osell);
        end
        side_out = {1'b0, (r.side ? osell : obuy)} + {1'b0, r.quantity};
        expo = r.side ? longint'(side_out) - longint'(r.position)
                      : longint'(r.position) + longint'(side_out);
        if (cnt.halt_flag) why = RSN_SHUTDOWN;
        else if (r.quantity > lim.max_order_qty) why = RSN_ORDER_QTY;
        else if (r.price < lim.min_price || r.price > lim.max_price ||
                 (PRICE_STEP_DEF > 1 && (r.price % PRICE_STEP_DEF) != 0)) why = RSN_PRICE;
        else if (side_out > lim.max_side_qty) why = RSN_SIDE_QTY;
        else if (expo > longint'(lim.max_side_exposure)) why = RSN_EXPOSURE;
        else if (expo > longint'(lim.max_projected_position)) why = RSN_POSITION;
        else if (cnt.sent_this_second >= lim.max_per_second) why = RSN_PER_SECOND;
        else if (cnt.sent_this_update >= MAX_PER_UPDATE_DEF) why = RSN_PER_MD;
        else if (cnt.in_flight >= lim.max_in_flight) why = RSN_IN_FLIGHT;
        o.accepted = (why == RSN_NONE);
      end
      OP_MD_UPD: cnt.sent_this_update = '0;
      OP_SENT: begin
        if (cnt.sent_this_second != 16'hFFFF) cnt.sent_this_second++;
        if (cnt.sent_this_update != 16'hFFFF) cnt.sent_this_update++;
        if (cnt.in_flight != 16'hFFFF) cnt.in_flight++;
      end
      OP_ACKED: if (cnt.in_flight != '0) cnt.in_flight--;
      OP_TICK: cnt.sent_this_second = '0;
      OP_SHUTDOWN: cnt.halt_flag = 1'b1;
      default: o.accepted = 1'b0;
    endcase
    o.reason = why;
    o.halted = cnt.halt_flag;
    return o;
  endfunction

  // Value around a limit: mostly inside, sometimes at the edge or anywhere
  function automatic logic [31:0] pick_u32(input logic [32:0] bound);
    logic [31:0] top;
    top = (bound > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : bound[31:0];
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return top - $urandom_range(0, 2);
      2:       return top + $urandom_range(0, 2);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned sel;
    logic [31:0] mag;
    sel = $urandom_range(0, 99);
    if (sel < 35) r.op = OP_NEW;
    else if (sel < 55) r.op = OP_MODIFY;
    else if (sel < 68) r.op = OP_SENT;
    else if (sel < 80) r.op = OP_ACKED;
    else if (sel < 88) r.op = OP_MD_UPD;
    else if (sel < 96) r.op = OP_TICK;
    else r.op = OP_UNUSED;
    r.side     = 1'($urandom_range(0, 1));
    r.old_side = 1'($urandom_range(0, 1));
    r.quantity = pick_u32({1'b0, lim.max_order_qty});
    if (lim.min_price <= lim.max_price && $urandom_range(0, 3) != 0) begin
      r.price = lim.min_price + $urandom_range(0, lim.max_price - lim.min_price);
    end else begin
      case ($urandom_range(0, 2))
        0:       r.price = $urandom;
        1:       r.price = lim.min_price - 1;
        default: r.price = lim.max_price + 1;
      endcase
    end
    case ($urandom_range(0, 3))
      0: r.position = $urandom;
      1: r.position = $urandom_range(0, 2048) - 1024;
      default: begin
        mag = pick_u32(lim.max_side_exposure >> 1);
        r.position = $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
    r.outstanding_buy  = pick_u32({1'b0, lim.max_side_qty >> 1});
    r.outstanding_sell = pick_u32({1'b0, lim.max_side_qty >> 1});
    r.old_qty = pick_u32({1'b0, (r.old_side ? r.outstanding_sell : r.outstanding_buy)});
    return r;
  endfunction

  // Event with random payload
  function automatic req_t event_req(input logic [2:0] op);
    req_t r;
    r    = rand_req();
    r.op = op;
    return r;
  endfunction

  function automatic req_t order_req(input logic [2:0] op, input logic side,
                                     input logic [31:0] qty, input logic [31:0] price,
                                     input logic [31:0] pos, input logic [31:0] obuy,
                                     input logic [31:0] osell, input logic old_side,
                                     input logic [31:0] old_qty);
    req_t r;
    r.op               = op;
    r.side             = side;
    r.quantity         = qty;
    r.price            = price;
    r.position         = pos;
    r.outstanding_buy  = obuy;
    r.outstanding_sell = osell;
    r.old_side         = old_side;
    r.old_qty          = old_qty;
    return r;
  endfunction

  function automatic req_t plain_order();
    return order_req(OP_NEW, 1'b0, 32'd1, 32'd500, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0);
  endfunction

  // Offer one request in bursts with random gaps; log its verdict on transfer
  task automatic send_req(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(risk_verdict(r));
  endtask

  // Drop valid and wait until every reply is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access until pready
  task automatic write_limit(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MAX_ORDER_QTY:  lim.max_order_qty          = val[31:0];
      REG_MIN_PRICE:      lim.min_price              = val[31:0];
      REG_MAX_PRICE:      lim.max_price              = val[31:0];
      REG_MAX_SIDE_QTY:   lim.max_side_qty           = val[31:0];
      REG_MAX_SIDE_EXPO:  lim.max_side_exposure      = val[32:0];
      REG_MAX_PROJ_POS:   lim.max_projected_position = val[32:0];
      REG_MAX_PER_SECOND: lim.max_per_second         = val[15:0];
      REG_MAX_IN_FLIGHT:  lim.max_in_flight          = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_limits(input cfg_t c);
    wait_idle();
    write_limit(REG_MAX_ORDER_QTY,  64'(c.max_order_qty));
    write_limit(REG_MIN_PRICE,      64'(c.min_price));
    write_limit(REG_MAX_PRICE,      64'(c.max_price));
    write_limit(REG_MAX_SIDE_QTY,   64'(c.max_side_qty));
    write_limit(REG_MAX_SIDE_EXPO,  64'(c.max_side_exposure));
    write_limit(REG_MAX_PROJ_POS,   64'(c.max_projected_position));
    write_limit(REG_MAX_PER_SECOND, 64'(c.max_per_second));
    write_limit(REG_MAX_IN_FLIGHT,  64'(c.max_in_flight));
  endtask

  function automatic cfg_t rand_limits();
    cfg_t c;
    c.max_order_qty          = $urandom_range(1, 5000);
    c.min_price              = $urandom_range(0, 1000);
    c.max_price              = c.min_price + $urandom_range(0, 100000);
    c.max_side_qty           = $urandom_range(0, 20000);
    c.max_side_exposure      = 33'($urandom_range(0, 25000));
    c.max_projected_position = 33'($urandom_range(0, 25000));
    c.max_per_second         = 16'($urandom_range(1, 40));
    c.max_in_flight          = 16'($urandom_range(1, 40));
    return c;
  endfunction

  // Reset limits: only a zero-quantity order gets past the size checks
  task automatic test_reset_limits();
    send_req(event_req(OP_ACKED));
    send_req(event_req(OP_UNUSED));
    send_req(order_req(OP_NEW, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd0, 32'd7, 32'd0, 32'd1, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd0, 32'd7, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 32'd0));
  endtask

  // Walk every reject reason but shutdown, with the rate limits last
  task automatic test_reject_reasons();
    cfg_t c;
    c = '{max_order_qty: 32'd1000, min_price: 32'd100, max_price: 32'd10000,
          max_side_qty: 32'd5000, max_side_exposure: 33'd4000,
          max_projected_position: 33'd3000, max_per_second: 16'd10, max_in_flight: 16'd10};
    load_limits(c);
    send_req(order_req(OP_NEW, 1'b0, 32'd1001, 32'd500, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b1, '1, 32'd500, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd10, 32'd99, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd10, 32'd10001, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd10, '1, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd1000, 32'd100, 32'd0, 32'd4001, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b1, 32'd10, 32'd10000, 32'd0, 32'd0, '1, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd10, 32'd500, 32'd3995, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b1, 32'd10, 32'd500, -32'sd3500, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b0, 32'd1000, 32'd500, 32'h8000_0000, 32'd4000, 32'd0,
                       1'b0, 32'd0));
    send_req(order_req(OP_NEW, 1'b1, 32'd5, 32'd500, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 32'd0));
    // Modify: old quantity larger than outstanding clamps at zero
    send_req(order_req(OP_MODIFY, 1'b1, 32'd100, 32'd500, 32'd0, 32'd0, 32'd20, 1'b1, '1));
    // Modify: old quantity on the other side leaves this side untouched
    send_req(order_req(OP_MODIFY, 1'b0, 32'd1000, 32'd500, 32'd0, 32'd4500, 32'd700,
                       1'b1, 32'd600));
    send_req(order_req(OP_MODIFY, 1'b0, 32'd1000, 32'd500, -32'sd1000, 32'd4500, 32'd0,
                       1'b0, 32'd600));
    // Rate limits: per update, per second, in flight
    repeat (MAX_PER_UPDATE_DEF) send_req(event_req(OP_SENT));
    send_req(plain_order());
    send_req(event_req(OP_MD_UPD));
    send_req(plain_order());
    repeat (2) send_req(event_req(OP_SENT));
    send_req(plain_order());
    send_req(event_req(OP_TICK));
    send_req(plain_order());
    send_req(event_req(OP_ACKED));
    send_req(plain_order());
  endtask

  task automatic run_phase(input cfg_t c, input int unsigned n);
    load_limits(c);
    repeat (n) send_req(rand_req());
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    c           = '1;
    c.min_price = '0;
    run_phase(c, PHASE_ITEMS);
    run_phase('0, PHASE_ITEMS);
    c           = rand_limits();
    c.min_price = '1;
    c.max_price = '1;
    run_phase(c, PHASE_ITEMS);
    repeat (2) run_phase(rand_limits(), PHASE_ITEMS);
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    load_limits(rand_limits());
    hold_off_req = 1'b1;
    repeat (60) send_req(rand_req());
  endtask

  // Pile up sent events on all three counters, then release one at a time
  task automatic test_counter_saturation();
    cfg_t c;
    c           = '1;
    c.min_price = '0;
    load_limits(c);
    repeat (SAT_SENTS) send_req(event_req(OP_SENT));
    send_req(plain_order());
    send_req(event_req(OP_TICK));
    send_req(plain_order());
    send_req(event_req(OP_MD_UPD));
    send_req(plain_order());
    send_req(event_req(OP_ACKED));
    send_req(plain_order());
  endtask

  // Shutdown is sticky and rejects ahead of every other check
  task automatic test_shutdown();
    send_req(event_req(OP_SHUTDOWN));
    send_req(plain_order());
    send_req(order_req(OP_NEW, 1'b1, '1, '1, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_req(event_req(OP_MODIFY));
    send_req(event_req(OP_SENT));
    send_req(event_req(OP_UNUSED));
    send_req(event_req(OP_SHUTDOWN));
    repeat (20) send_req(rand_req());
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each reply transfer with the oldest predicted verdict
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("reply with no request outstanding");
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data_o.accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_data_o.accepted);
          mismatches++;
        end
        if (out_data_o.reason !== want.reason) begin
          $error("reason: expected %0d, got %0d", want.reason, out_data_o.reason);
          mismatches++;
        end
        if (out_data_o.halted !== want.halted) begin
          $error("halted: expected %0b, got %0b", want.halted, out_data_o.halted);
          mismatches++;
        end
      end
    end
  end

  // Abort when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    lim           = '0;
    lim.max_price = '1;
    cnt           = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limits();
    test_reject_reasons();
    test_random_traffic();
    test_backpressure();
    test_counter_saturation();
    test_shutdown();
    wait_idle();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
src/prc_pkg.sv
src/prc_cfg_regs.sv
src/prc_check.sv
src/pretrade_risk_check_core.sv
src/prc_checker.sv
tb/tb_pretrade_risk_check_core.sv
